// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== sv/kpsf_pkg.sv =====
`timescale 1ns / 1ps

package kpsf_pkg;

  localparam int WORD_W    = 32;
  localparam int SUM_W     = 40;
  localparam int MUL_A_W   = 35;
  localparam int MUL_B_W   = 34;
  localparam int MUL_R_W   = 40;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_STEPS = 34;

  localparam logic [31:0] RST_SAMPLE_PERIOD  = 32'd429497;
  localparam logic [30:0] RST_POSITION_NOISE = 31'd1073742;
  localparam logic [30:0] RST_SPEED_NOISE    = 31'd107374182;
  localparam logic [30:0] RST_MEASURE_NOISE  = 31'd10737418;
  localparam logic [31:0] RST_COV_POS_POS    = 32'd10737418;
  localparam logic [31:0] RST_COV_SPD_SPD    = 32'd107374182;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[WORD_W-1:0];
    end else if (v < lo) begin
      return lo[WORD_W-1:0];
    end
    return v[WORD_W-1:0];
  endfunction

endpackage

// ===== sv/kpsf_mul.sv =====
`timescale 1ns / 1ps

module kpsf_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                sh32,
  input  logic signed [kpsf_pkg::MUL_A_W-1:0] a,
  input  logic signed [kpsf_pkg::MUL_B_W-1:0] b,
  output kpsf_pkg::unit_stat_t                stat,
  output logic signed [kpsf_pkg::MUL_R_W-1:0] res
);

  localparam logic [2:0] MPH_IDLE = 3'd0;
  localparam logic [2:0] MPH_LO   = 3'd1;
  localparam logic [2:0] MPH_HI   = 3'd2;
  localparam logic [2:0] MPH_ACC  = 3'd3;
  localparam logic [2:0] MPH_RND  = 3'd4;

  logic [2:0]  ph_r;
  logic [33:0] ma_r;
  logic [32:0] mb_r;
  logic        neg_r;
  logic        sh32_r;
  logic [66:0] acc_r;
  logic [50:0] pp_r;
  logic        done_r;
  logic signed [kpsf_pkg::MUL_R_W-1:0] res_r;

  logic [34:0] a_abs;
  logic [33:0] b_abs;
  logic [16:0] mul_b;
  logic [50:0] prod;
  logic [67:0] rnd_sum;
  logic [37:0] rmag;

  assign a_abs   = a[kpsf_pkg::MUL_A_W-1] ? 35'(-a) : 35'(a);
  assign b_abs   = b[kpsf_pkg::MUL_B_W-1] ? 34'(-b) : 34'(b);
  assign mul_b   = (ph_r == MPH_LO) ? mb_r[16:0] : {1'b0, mb_r[32:17]};
  assign prod    = 51'(ma_r) * 51'(mul_b);
  assign rnd_sum = {1'b0, acc_r} + (sh32_r ? (68'd1 << 31) : (68'd1 << 29));
  assign rmag    = sh32_r ? 38'(rnd_sum >> 32) : 38'(rnd_sum >> 30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= MPH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (ph_r)
        MPH_IDLE: begin
          if (start) begin
            ph_r <= MPH_LO;
          end
        end
        MPH_LO:  ph_r <= MPH_HI;
        MPH_HI:  ph_r <= MPH_ACC;
        MPH_ACC: ph_r <= MPH_RND;
        MPH_RND: begin
          ph_r   <= MPH_IDLE;
          done_r <= 1'b1;
        end
        default: ph_r <= MPH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ph_r == MPH_IDLE && start) begin
      ma_r   <= a_abs[33:0];
      mb_r   <= b_abs[32:0];
      neg_r  <= a[kpsf_pkg::MUL_A_W-1] ^ b[kpsf_pkg::MUL_B_W-1];
      sh32_r <= sh32;
    end
    if (ph_r == MPH_LO) begin
      acc_r <= 67'(prod);
    end
    if (ph_r == MPH_HI) begin
      pp_r <= prod;
    end
    if (ph_r == MPH_ACC) begin
      acc_r <= acc_r + (67'(pp_r) << 17);
    end
    if (ph_r == MPH_RND) begin
      res_r <= neg_r ? -(40'(rmag)) : 40'(rmag);
    end
  end

  assign stat.busy = (ph_r != MPH_IDLE);
  assign stat.done = done_r;
  assign res       = res_r;

endmodule

// ===== sv/kpsf_div.sv =====
`timescale 1ns / 1ps

module kpsf_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [kpsf_pkg::WORD_W-1:0]    num,
  input  logic signed [kpsf_pkg::DIV_DEN_W-1:0] den,
  output kpsf_pkg::unit_stat_t                  stat,
  output logic signed [kpsf_pkg::WORD_W-1:0]    gain
);

  localparam logic [1:0] DPH_IDLE = 2'd0;
  localparam logic [1:0] DPH_RUN  = 2'd1;
  localparam logic [1:0] DPH_FIN  = 2'd2;

  logic [1:0]  ph_r;
  logic [32:0] md_r;
  logic [32:0] rem_r;
  logic [33:0] nlo_r;
  logic [33:0] q_r;
  logic [5:0]  cnt_r;
  logic        neg_r;
  logic        sat_r;
  logic        zero_r;
  logic        done_r;
  logic signed [kpsf_pkg::WORD_W-1:0] g_r;

  logic [32:0] num_abs;
  logic [32:0] den_abs;
  logic [61:0] n_full;
  logic [33:0] trial;
  logic        ge;
  logic [33:0] diff;
  logic        big;

  assign num_abs = num[kpsf_pkg::WORD_W-1] ? 33'(-num) : 33'(num);
  assign den_abs = den[kpsf_pkg::DIV_DEN_W-1] ? 33'(-den) : 33'(den);
  assign n_full  = (62'(num_abs[31:0]) << 30) + 62'(den_abs >> 1);
  assign trial   = {rem_r, nlo_r[33]};
  assign ge      = (trial >= {1'b0, md_r});
  assign diff    = trial - {1'b0, md_r};
  assign big     = sat_r || (q_r[33:31] != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= DPH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (ph_r)
        DPH_IDLE: begin
          if (start) begin
            ph_r <= (den == '0) ? DPH_FIN : DPH_RUN;
          end
        end
        DPH_RUN: begin
          if (cnt_r == 6'd0) begin
            ph_r <= DPH_FIN;
          end
        end
        DPH_FIN: begin
          ph_r   <= DPH_IDLE;
          done_r <= 1'b1;
        end
        default: ph_r <= DPH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ph_r == DPH_IDLE && start) begin
      md_r   <= den_abs;
      rem_r  <= 33'(n_full[61:34]);
      nlo_r  <= n_full[33:0];
      q_r    <= '0;
      cnt_r  <= 6'(kpsf_pkg::DIV_STEPS - 1);
      neg_r  <= num[kpsf_pkg::WORD_W-1] ^ den[kpsf_pkg::DIV_DEN_W-1];
      sat_r  <= (33'(n_full[61:34]) >= den_abs);
      zero_r <= (den == '0);
    end
    if (ph_r == DPH_RUN) begin
      rem_r <= ge ? diff[32:0] : trial[32:0];
      nlo_r <= {nlo_r[32:0], 1'b0};
      q_r   <= {q_r[32:0], ge};
      cnt_r <= cnt_r - 6'd1;
    end
    if (ph_r == DPH_FIN) begin
      if (zero_r) begin
        g_r <= '0;
      end else if (neg_r) begin
        g_r <= big ? 32'sh8000_0000 : -(32'({1'b0, q_r[30:0]}));
      end else begin
        g_r <= big ? 32'sh7FFF_FFFF : 32'({1'b0, q_r[30:0]});
      end
    end
  end

  assign stat.busy = (ph_r != DPH_IDLE);
  assign stat.done = done_r;
  assign gain      = g_r;

endmodule

// ===== sv/kalman_position_speed_filter_unit.sv =====
`timescale 1ns / 1ps
// Ten products run one at a time on the shared multiplier, and two gains on the shared
// radix-2 divider. The input stalls while a sample runs, so a new input is accepted
// only once the previous sample has been handed to the output registers.
// Reset (synchronous, rst_n low) loads the default registers and the initial covariance.

`include "assert_macros.svh"

module kalman_position_speed_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_measured_pos,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_speed_estimate,
  output logic [31:0] out_position_estimate,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [1:0] CFG_SAMPLE_PERIOD  = 2'd0;
  localparam logic [1:0] CFG_POSITION_NOISE = 2'd1;
  localparam logic [1:0] CFG_SPEED_NOISE    = 2'd2;
  localparam logic [1:0] CFG_MEASURE_NOISE  = 2'd3;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M1   = 4'd1;
  localparam logic [3:0] ST_M2   = 4'd2;
  localparam logic [3:0] ST_M3   = 4'd3;
  localparam logic [3:0] ST_M4   = 4'd4;
  localparam logic [3:0] ST_D1   = 4'd5;
  localparam logic [3:0] ST_D2   = 4'd6;
  localparam logic [3:0] ST_M5   = 4'd7;
  localparam logic [3:0] ST_M6   = 4'd8;
  localparam logic [3:0] ST_M7   = 4'd9;
  localparam logic [3:0] ST_M8   = 4'd10;
  localparam logic [3:0] ST_M9   = 4'd11;
  localparam logic [3:0] ST_M10  = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;

  logic [3:0]  state_r;
  logic        issued_r;
  logic [31:0] dt_r;
  logic [30:0] pn_r;
  logic [30:0] sn_r;
  logic [30:0] mn_r;

  logic signed [31:0] est_pos_r;
  logic signed [31:0] est_spd_r;
  logic signed [31:0] c00_r;
  logic signed [31:0] c01_r;
  logic signed [31:0] c10_r;
  logic signed [31:0] c11_r;
  logic signed [31:0] meas_r;
  logic signed [31:0] pos_pred_r;
  logic signed [32:0] p11dt_r;
  logic signed [34:0] inner_r;
  logic signed [31:0] p00_r;
  logic signed [31:0] p01_r;
  logic signed [31:0] p10_r;
  logic signed [31:0] p11_r;
  logic signed [32:0] innov_r;
  logic signed [31:0] k0_r;
  logic signed [31:0] k1_r;
  logic               out_valid_r;
  logic [31:0]        out_spd_r;
  logic [31:0]        out_pos_r;

  logic                          is_mul;
  logic                          is_div;
  logic                          mul_start;
  logic                          div_start;
  logic                          sh32;
  logic signed [34:0]            mul_a;
  logic signed [33:0]            mul_b;
  logic signed [39:0]            mr;
  logic signed [32:0]            s_den;
  logic signed [31:0]            div_num;
  logic signed [31:0]            div_gain;
  logic signed [33:0]            dt_op;
  kpsf_pkg::unit_stat_t          mul_stat;
  kpsf_pkg::unit_stat_t          div_stat;
  logic                          unit_done;
  logic                          out_free;

  assign is_mul    = (state_r == ST_M1) || (state_r == ST_M2) || (state_r == ST_M3) ||
                     (state_r == ST_M4) || (state_r == ST_M5) || (state_r == ST_M6) ||
                     (state_r == ST_M7) || (state_r == ST_M8) || (state_r == ST_M9) ||
                     (state_r == ST_M10);
  assign is_div    = (state_r == ST_D1) || (state_r == ST_D2);
  assign mul_start = is_mul && !issued_r;
  assign div_start = is_div && !issued_r;
  assign unit_done = mul_stat.done || div_stat.done;
  assign out_free  = !out_valid_r || !out_stall;
  assign dt_op     = 34'({2'b00, dt_r});
  assign s_den     = 33'(p00_r) + 33'({1'b0, mn_r});
  assign div_num   = (state_r == ST_D1) ? p00_r : p10_r;

  always_comb begin
    mul_a = 35'(est_spd_r);
    mul_b = dt_op;
    sh32  = 1'b1;
    unique case (state_r)
      ST_M1: begin
        mul_a = 35'(est_spd_r);
      end
      ST_M2: begin
        mul_a = 35'(c11_r);
      end
      ST_M3: begin
        mul_a = 35'(p11dt_r);
      end
      ST_M4: begin
        mul_a = inner_r;
      end
      ST_M5: begin
        mul_a = 35'(k0_r);
        mul_b = 34'(innov_r);
        sh32  = 1'b0;
      end
      ST_M6: begin
        mul_a = 35'(k1_r);
        mul_b = 34'(innov_r);
        sh32  = 1'b0;
      end
      ST_M7: begin
        mul_a = 35'(k0_r);
        mul_b = 34'(p00_r);
        sh32  = 1'b0;
      end
      ST_M8: begin
        mul_a = 35'(k0_r);
        mul_b = 34'(p01_r);
        sh32  = 1'b0;
      end
      ST_M9: begin
        mul_a = 35'(k1_r);
        mul_b = 34'(p00_r);
        sh32  = 1'b0;
      end
      ST_M10: begin
        mul_a = 35'(k1_r);
        mul_b = 34'(p01_r);
        sh32  = 1'b0;
      end
      default: begin
        mul_a = 35'(est_spd_r);
      end
    endcase
  end

  kpsf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .sh32  (sh32),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .res   (mr)
  );

  kpsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (s_den),
    .stat  (div_stat),
    .gain  (div_gain)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      dt_r        <= kpsf_pkg::RST_SAMPLE_PERIOD;
      pn_r        <= kpsf_pkg::RST_POSITION_NOISE;
      sn_r        <= kpsf_pkg::RST_SPEED_NOISE;
      mn_r        <= kpsf_pkg::RST_MEASURE_NOISE;
      est_pos_r   <= '0;
      est_spd_r   <= '0;
      c00_r       <= kpsf_pkg::RST_COV_POS_POS;
      c01_r       <= '0;
      c10_r       <= '0;
      c11_r       <= kpsf_pkg::RST_COV_SPD_SPD;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SAMPLE_PERIOD:  dt_r <= cfg_data;
          CFG_POSITION_NOISE: pn_r <= cfg_data[30:0];
          CFG_SPEED_NOISE:    sn_r <= cfg_data[30:0];
          CFG_MEASURE_NOISE:  mn_r <= cfg_data[30:0];
          default:            dt_r <= dt_r;
        endcase
      end

      if (out_valid_r && !out_stall && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end

      if (mul_start || div_start) begin
        issued_r <= 1'b1;
      end else if (unit_done) begin
        issued_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            meas_r  <= in_measured_pos;
            state_r <= ST_M1;
          end
        end
        ST_M1: begin
          if (mul_stat.done) begin
            pos_pred_r <= kpsf_pkg::sat_word(40'(est_pos_r) + mr);
            state_r    <= ST_M2;
          end
        end
        ST_M2: begin
          if (mul_stat.done) begin
            p11dt_r <= 33'(mr);
            p01_r   <= kpsf_pkg::sat_word(40'(c01_r) + mr);
            p10_r   <= kpsf_pkg::sat_word(40'(c10_r) + mr);
            p11_r   <= kpsf_pkg::sat_word(40'(c11_r) + 40'({1'b0, sn_r}));
            state_r <= ST_M3;
          end
        end
        ST_M3: begin
          if (mul_stat.done) begin
            inner_r <= 35'(c10_r) + 35'(c01_r) + 35'(mr);
            state_r <= ST_M4;
          end
        end
        ST_M4: begin
          if (mul_stat.done) begin
            p00_r   <= kpsf_pkg::sat_word(40'(c00_r) + mr + 40'({1'b0, pn_r}));
            innov_r <= 33'(meas_r) - 33'(pos_pred_r);
            state_r <= ST_D1;
          end
        end
        ST_D1: begin
          if (div_stat.done) begin
            k0_r    <= div_gain;
            state_r <= ST_D2;
          end
        end
        ST_D2: begin
          if (div_stat.done) begin
            k1_r    <= div_gain;
            state_r <= ST_M5;
          end
        end
        ST_M5: begin
          if (mul_stat.done) begin
            est_pos_r <= kpsf_pkg::sat_word(40'(pos_pred_r) + mr);
            state_r   <= ST_M6;
          end
        end
        ST_M6: begin
          if (mul_stat.done) begin
            est_spd_r <= kpsf_pkg::sat_word(40'(est_spd_r) + mr);
            state_r   <= ST_M7;
          end
        end
        ST_M7: begin
          if (mul_stat.done) begin
            c00_r   <= kpsf_pkg::sat_word(40'(p00_r) - mr);
            state_r <= ST_M8;
          end
        end
        ST_M8: begin
          if (mul_stat.done) begin
            c01_r   <= kpsf_pkg::sat_word(40'(p01_r) - mr);
            state_r <= ST_M9;
          end
        end
        ST_M9: begin
          if (mul_stat.done) begin
            c10_r   <= kpsf_pkg::sat_word(40'(p10_r) - mr);
            state_r <= ST_M10;
          end
        end
        ST_M10: begin
          if (mul_stat.done) begin
            c11_r   <= kpsf_pkg::sat_word(40'(p11_r) - mr);
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_spd_r   <= est_spd_r;
            out_pos_r   <= est_pos_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall              = (state_r != ST_IDLE);
  assign cfg_ready             = 1'b1;
  assign out_valid             = out_valid_r;
  assign out_speed_estimate    = out_spd_r;
  assign out_position_estimate = out_pos_r;

  `ASSERT_CLK(a_accept_starts, in_valid && !in_stall |=> state_r == ST_M1, "accept did not start a sample")
  `ASSERT_NEVER(a_done_overlap, mul_stat.done && div_stat.done, "both units finished together")
  `ASSERT_CLK(a_idle_quiet, state_r == ST_IDLE |-> !mul_stat.busy && !div_stat.busy, "unit busy while idle")
  `ASSERT_CLK(a_out_load, state_r == ST_OUT && out_free |=> out_valid && state_r == ST_IDLE, "result not loaded")

endmodule
